### sv/tnrn_pkg.sv
// ----------------------------------------------------------------------------
// Telnet receive negotiator package
// Shared byte codes, result kinds, reply segment codes and the reply plan type.
// ----------------------------------------------------------------------------
package tnrn_pkg;

  // Telnet command bytes.
  localparam logic [7:0] TN_IAC  = 8'd255;
  localparam logic [7:0] TN_DONT = 8'd254;
  localparam logic [7:0] TN_DO   = 8'd253;
  localparam logic [7:0] TN_WONT = 8'd252;
  localparam logic [7:0] TN_WILL = 8'd251;
  localparam logic [7:0] TN_SB   = 8'd250;
  localparam logic [7:0] TN_DM   = 8'd242;
  localparam logic [7:0] TN_SE   = 8'd240;
  localparam logic [7:0] TN_EOR  = 8'd239;

  // Option codes.
  localparam logic [7:0] OPT_BINARY = 8'd0;
  localparam logic [7:0] OPT_ECHO   = 8'd1;
  localparam logic [7:0] OPT_SGA    = 8'd3;
  localparam logic [7:0] OPT_TTYPE  = 8'd24;
  localparam logic [7:0] OPT_EOR    = 8'd25;

  // Terminal-type subnegotiation codes.
  localparam logic [7:0] TT_IS   = 8'd0;
  localparam logic [7:0] TT_SEND = 8'd1;
  localparam logic [7:0] NAME_PAD = 8'h2D;

  // Default length of the terminal name.
  localparam int unsigned TermNameLenDef = 10;

  // Stock terminal name prefix.
  localparam int unsigned NamePrefixLen = 9;
  localparam logic [7:0] NAME_PREFIX [NamePrefixLen] = '{
    8'h49, 8'h42, 8'h4D, 8'h2D, 8'h33, 8'h32, 8'h37, 8'h38, 8'h2D
  };

  // Configuration register indexes.
  localparam logic CFG_ALLOW_REFUSE = 1'b0;
  localparam logic CFG_MODEL_DIGIT  = 1'b1;

  // Result kinds.
  typedef enum logic [3:0] {
    K_DATA3270  = 4'd0,
    K_ANSI      = 4'd1,
    K_REC_END   = 4'd2,
    K_NET       = 4'd3,
    K_ENTER3270 = 4'd4,
    K_DISC      = 4'd5,
    K_EXC_ON    = 4'd6,
    K_LINEMODE  = 4'd7,
    K_EXC_OFF   = 4'd8
  } kind_e;

  // Reply segments, delivered in ascending bit order.
  localparam logic [5:0] SEG_HEAD  = 6'b000001; // one data or event result
  localparam logic [5:0] SEG_REPLY = 6'b000010; // IAC, verb, option
  localparam logic [5:0] SEG_TERM  = 6'b000100; // terminal-type answer
  localparam logic [5:0] SEG_MODE  = 6'b001000; // entered 3270 or disconnect
  localparam logic [5:0] SEG_LINE  = 6'b010000; // line mode changed
  localparam logic [5:0] SEG_EOR   = 6'b100000; // IAC DO EOR

  // Everything the emitter needs to play back the results of one item.
  typedef struct packed {
    logic [5:0] seg;
    kind_e      head_kind;
    logic [7:0] head_value;
    logic       head_discard;
    logic       head_lm;
    logic [7:0] reply_verb;
    logic [7:0] reply_opt;
    logic       mode_disc;
    logic       lm_pre;
    logic       lm_post;
  } plan_t;

  // Byte of the terminal name prefix, padded beyond its length.
  function automatic logic [7:0] name_char(logic [7:0] pos);
    logic [7:0] ch;
    ch = NAME_PAD;
    if (pos < 8'(NamePrefixLen)) begin
      ch = NAME_PREFIX[pos[3:0]];
    end
    return ch;
  endfunction

endpackage

### sv/telnet_receive_negotiator.sv
// ----------------------------------------------------------------------------
// Telnet receive negotiator
// Word path: a word is registered in the input register, and its plan is then
// loaded into the result sequencer, which offers the first result.
// Throughput: one word per cycle while each word gives at most one result and
// the result channel is ready; a word with more results holds the result
// sequencer until its last result is taken, stalling the input meanwhile.
// Reset clears all protocol state at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module telnet_receive_negotiator #(
  parameter int unsigned TERM_NAME_LEN = tnrn_pkg::TermNameLenDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration write port.
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [5:0] cfg_wdata_i,
  // Input channel.
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       cmd_i,
  input  logic [7:0] rx_byte_i,
  // Result channel.
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] kind_o,
  output logic [7:0] value_o,
  output logic       discard_o,
  output logic       line_mode_o,
  output logic       last_o
);
  import tnrn_pkg::*;

  // Configuration registers. The first lets the host refuse an essential
  // option without tearing the session down; the second is the ASCII digit
  // that closes the terminal name.
  logic       allow_q;
  logic [5:0] digit_q;

  // Input register. A word sits here while the decoder looks at it, and moves
  // on as soon as the result sequencer can take its plan.
  logic       in_vld_q;
  logic       cmd_q;
  logic [7:0] rx_q;

  logic  take;
  logic  step;
  plan_t plan;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allow_q <= 1'b0;
      digit_q <= 6'd52;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ALLOW_REFUSE: allow_q <= cfg_wdata_i[0];
        CFG_MODEL_DIGIT:  digit_q <= cfg_wdata_i;
        default:          allow_q <= allow_q;
      endcase
    end
  end

  // The input side is free when the register is empty or its word is being
  // handed to the sequencer in this cycle, so a new word can enter every
  // cycle while the sequencer has no more than one result to deliver and the result channel is ready.
  assign in_ready_o = !in_vld_q || take;
  assign step       = in_vld_q && take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= cmd_i;
      rx_q  <= rx_byte_i;
    end
  end

  // The decoder owns the parser and option state and commits its update in
  // the same cycle as the plan is loaded into the sequencer, so the next word
  // always sees the state left by this one.
  tnrn_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .cmd_i     (cmd_q),
    .rx_byte_i (rx_q),
    .allow_i   (allow_q),
    .plan_o    (plan)
  );

  // The sequencer walks through the plan's segments in a fixed order: the
  // single data or event result, the three-byte option reply, the terminal
  // name answer, the mode event, the line mode event and the closing DO EOR.
  tnrn_emit #(
    .TERM_NAME_LEN (TERM_NAME_LEN)
  ) u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (step),
    .plan_i        (plan),
    .model_digit_i (digit_q),
    .take_o        (take),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .value_o       (value_o),
    .discard_o     (discard_o),
    .line_mode_o   (line_mode_o),
    .last_o        (last_o)
  );

  // A disconnect always reports line mode as it stands after the state wipe.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o == K_DISC)) |-> line_mode_o)
    else $error("disconnect result without line mode set");

  // Only data and network bytes carry a value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o != K_DATA3270) && (kind_o != K_ANSI) && (kind_o != K_NET))
    |-> (value_o == 8'd0))
    else $error("event result carries a value");

  // Only ANSI data and record ends can be marked for dropping.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && discard_o) |-> ((kind_o == K_ANSI) || (kind_o == K_REC_END)))
    else $error("discard flag on a result kind that cannot be dropped");

  // A word waiting in the input register is neither lost nor overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !take) |=> (in_vld_q && $stable(rx_q) && $stable(cmd_q)))
    else $error("held input word changed before it was decoded");

endmodule

### sv/tnrn_decode.sv
// ----------------------------------------------------------------------------
// Telnet receive negotiator decoder
// Holds the protocol state and turns one item into a plan of results.
// ----------------------------------------------------------------------------
module tnrn_decode (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic            cmd_i,
  input  logic [7:0]      rx_byte_i,
  input  logic            allow_i,
  output tnrn_pkg::plan_t plan_o
);
  import tnrn_pkg::*;

  typedef enum logic [7:0] {
    PS_DATA   = 8'b00000001,
    PS_IAC    = 8'b00000010,
    PS_WILL   = 8'b00000100,
    PS_WONT   = 8'b00001000,
    PS_DO     = 8'b00010000,
    PS_DONT   = 8'b00100000,
    PS_SB     = 8'b01000000,
    PS_SB_IAC = 8'b10000000
  } pstate_e;

  pstate_e    ps_q, ps_d;
  logic [4:0] peer_q, peer_d;
  logic [3:0] local_q, local_d;
  logic [7:0] first_q, first_d, second_q, second_d;
  logic [1:0] count_q, count_d;
  logic       sync_q, sync_d, m3270_q, m3270_d, lm_q, lm_d;

  logic [4:0] pb;
  logic [3:0] lb;
  logic       ess, chk_mode, chk_line, want_eor, wipe, now_3270, lm_new;
  plan_t      plan;

  // Peer option bits: BINARY, ECHO, SGA, TTYPE, EOR.
  function automatic logic [4:0] peer_bit(logic [7:0] c);
    logic [4:0] b;
    case (c)
      OPT_BINARY: b = 5'b00001;
      OPT_ECHO:   b = 5'b00010;
      OPT_SGA:    b = 5'b00100;
      OPT_TTYPE:  b = 5'b01000;
      OPT_EOR:    b = 5'b10000;
      default:    b = 5'b00000;
    endcase
    return b;
  endfunction

  // Local option bits: BINARY, SGA, TTYPE, EOR.
  function automatic logic [3:0] local_bit(logic [7:0] c);
    logic [3:0] b;
    case (c)
      OPT_BINARY: b = 4'b0001;
      OPT_SGA:    b = 4'b0010;
      OPT_TTYPE:  b = 4'b0100;
      OPT_EOR:    b = 4'b1000;
      default:    b = 4'b0000;
    endcase
    return b;
  endfunction

  assign pb  = peer_bit(rx_byte_i);
  assign lb  = local_bit(rx_byte_i);
  assign ess = (rx_byte_i == OPT_BINARY) || (rx_byte_i == OPT_EOR) ||
               (rx_byte_i == OPT_TTYPE);

  always_comb begin
    ps_d     = ps_q;
    peer_d   = peer_q;
    local_d  = local_q;
    first_d  = first_q;
    second_d = second_q;
    count_d  = count_q;
    sync_d   = sync_q;
    m3270_d  = m3270_q;
    lm_d     = lm_q;
    plan         = '0;
    plan.head_kind = K_DATA3270;
    plan.head_lm = lm_q;
    plan.lm_pre  = lm_q;
    plan.lm_post = lm_q;
    chk_mode = 1'b0;
    chk_line = 1'b0;
    want_eor = 1'b0;
    wipe     = 1'b0;
    now_3270 = 1'b0;
    lm_new   = lm_q;

    if (cmd_i) begin
      if (!sync_q) begin
        sync_d         = 1'b1;
        plan.seg       = SEG_HEAD;
        plan.head_kind = K_EXC_OFF;
      end
    end else begin
      case (ps_q)
        PS_DATA: begin
          if (rx_byte_i == TN_IAC) begin
            ps_d = PS_IAC;
          end else begin
            plan.seg          = SEG_HEAD;
            plan.head_kind    = m3270_q ? K_DATA3270 : K_ANSI;
            plan.head_value   = rx_byte_i;
            plan.head_discard = !m3270_q && sync_q;
          end
        end
        PS_IAC: begin
          ps_d = PS_DATA;
          case (rx_byte_i)
            TN_IAC: begin
              plan.seg          = SEG_HEAD;
              plan.head_kind    = m3270_q ? K_DATA3270 : K_ANSI;
              plan.head_value   = rx_byte_i;
              plan.head_discard = !m3270_q && sync_q;
            end
            TN_EOR: begin
              plan.seg          = SEG_HEAD;
              plan.head_kind    = K_REC_END;
              plan.head_discard = sync_q || !m3270_q;
            end
            TN_WILL: ps_d = PS_WILL;
            TN_WONT: ps_d = PS_WONT;
            TN_DO:   ps_d = PS_DO;
            TN_DONT: ps_d = PS_DONT;
            TN_SB: begin
              ps_d    = PS_SB;
              count_d = 2'd0;
            end
            TN_DM: begin
              if (sync_q) begin
                sync_d         = 1'b0;
                plan.seg       = SEG_HEAD;
                plan.head_kind = K_EXC_ON;
              end
            end
            default: ps_d = PS_DATA;
          endcase
        end
        PS_WILL: begin
          ps_d     = PS_DATA;
          chk_line = 1'b1;
          plan.reply_opt = rx_byte_i;
          if (pb != 5'd0) begin
            chk_mode = 1'b1;
            if ((peer_q & pb) == 5'd0) begin
              peer_d          = peer_q | pb;
              plan.seg        = SEG_REPLY;
              plan.reply_verb = TN_DO;
            end
          end else begin
            plan.seg        = SEG_REPLY;
            plan.reply_verb = TN_DONT;
          end
        end
        PS_WONT: begin
          ps_d = PS_DATA;
          if (ess && !allow_i) begin
            wipe           = 1'b1;
            plan.seg       = SEG_HEAD;
            plan.head_kind = K_DISC;
            plan.head_lm   = 1'b1;
          end else begin
            peer_d   = peer_q & ~pb;
            chk_mode = 1'b1;
            chk_line = 1'b1;
          end
        end
        PS_DO: begin
          ps_d = PS_DATA;
          plan.reply_opt = rx_byte_i;
          if (lb != 4'd0) begin
            chk_mode = 1'b1;
            if ((local_q & lb) == 4'd0) begin
              local_d         = local_q | lb;
              plan.seg        = SEG_REPLY;
              plan.reply_verb = TN_WILL;
            end
          end else begin
            plan.seg        = SEG_REPLY;
            plan.reply_verb = TN_WONT;
          end
        end
        PS_DONT: begin
          ps_d = PS_DATA;
          if (ess && !allow_i) begin
            wipe           = 1'b1;
            plan.seg       = SEG_HEAD;
            plan.head_kind = K_DISC;
            plan.head_lm   = 1'b1;
          end else begin
            local_d = local_q & ~lb;
          end
        end
        PS_SB, PS_SB_IAC: begin
          if ((ps_q == PS_SB) && (rx_byte_i == TN_IAC)) begin
            ps_d = PS_SB_IAC;
          end else if ((ps_q == PS_SB_IAC) && (rx_byte_i == TN_SE)) begin
            ps_d = PS_DATA;
            if ((count_q == 2'd2) && (first_q == OPT_TTYPE) && (second_q == TT_SEND)) begin
              plan.seg = SEG_TERM;
              chk_mode = 1'b1;
              want_eor = 1'b1;
            end
          end else begin
            // A byte after IAC other than SE is kept as one stored byte.
            ps_d = PS_SB;
            if (count_q == 2'd0) begin
              first_d = rx_byte_i;
            end else if (count_q == 2'd1) begin
              second_d = rx_byte_i;
            end
            if (count_q != 2'd2) begin
              count_d = count_q + 2'd1;
            end
          end
        end
        default: ps_d = PS_DATA;
      endcase
    end

    // 3270 mode needs local BINARY, TTYPE, EOR and peer BINARY, EOR.
    now_3270 = local_d[0] && local_d[2] && local_d[3] && peer_d[0] && peer_d[4];
    if (chk_mode && (now_3270 != m3270_q)) begin
      plan.seg = plan.seg | SEG_MODE;
      if (now_3270) begin
        m3270_d = 1'b1;
      end else begin
        plan.mode_disc = 1'b1;
        wipe           = 1'b1;
      end
    end

    lm_new = !peer_d[1];
    if (chk_line && !wipe && (lm_new != lm_q)) begin
      lm_d         = lm_new;
      plan.seg     = plan.seg | SEG_LINE;
      plan.lm_post = lm_new;
    end

    if (want_eor && !wipe) begin
      plan.seg = plan.seg | SEG_EOR;
    end

    if (wipe) begin
      ps_d     = PS_DATA;
      peer_d   = '0;
      local_d  = '0;
      first_d  = '0;
      second_d = '0;
      count_d  = '0;
      sync_d   = 1'b0;
      m3270_d  = 1'b0;
      lm_d     = 1'b1;
    end
  end

  assign plan_o = plan;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ps_q     <= PS_DATA;
      peer_q   <= '0;
      local_q  <= '0;
      first_q  <= '0;
      second_q <= '0;
      count_q  <= '0;
      sync_q   <= 1'b0;
      m3270_q  <= 1'b0;
      lm_q     <= 1'b1;
    end else if (step_i) begin
      ps_q     <= ps_d;
      peer_q   <= peer_d;
      local_q  <= local_d;
      first_q  <= first_d;
      second_q <= second_d;
      count_q  <= count_d;
      sync_q   <= sync_d;
      m3270_q  <= m3270_d;
      lm_q     <= lm_d;
    end
  end

endmodule

### sv/tnrn_emit.sv
// ----------------------------------------------------------------------------
// Telnet receive negotiator emitter
// Holds one reply plan and plays its results out one word per cycle while the result channel is ready.
// ----------------------------------------------------------------------------
module tnrn_emit #(
  parameter int unsigned TERM_NAME_LEN = tnrn_pkg::TermNameLenDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  tnrn_pkg::plan_t plan_i,
  input  logic [5:0]      model_digit_i,
  output logic            take_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [3:0]      kind_o,
  output logic [7:0]      value_o,
  output logic            discard_o,
  output logic            line_mode_o,
  output logic            last_o
);
  import tnrn_pkg::*;

  localparam int unsigned TermLast = TERM_NAME_LEN + 5;
  localparam int unsigned DigitPos = TERM_NAME_LEN + 3;
  localparam int unsigned CntW     = $clog2(TERM_NAME_LEN + 6);

  logic [5:0]      rem_q, rem_d, low;
  logic [CntW-1:0] cnt_q, cnt_d, seg_last;
  plan_t           p_q;
  kind_e           kind;
  logic [7:0]      value, term_byte, name_pos;
  logic            discard, lm, last_in_seg, last;

  assign low      = rem_q & (~rem_q + 6'd1);
  assign name_pos = 8'(cnt_q) - 8'd4;

  always_comb begin
    if (cnt_q == CntW'(0)) begin
      term_byte = TN_IAC;
    end else if (cnt_q == CntW'(1)) begin
      term_byte = TN_SB;
    end else if (cnt_q == CntW'(2)) begin
      term_byte = OPT_TTYPE;
    end else if (cnt_q == CntW'(3)) begin
      term_byte = TT_IS;
    end else if (cnt_q == CntW'(DigitPos)) begin
      term_byte = {2'b00, model_digit_i};
    end else if (cnt_q < CntW'(DigitPos)) begin
      term_byte = name_char(name_pos);
    end else if (cnt_q == CntW'(DigitPos + 1)) begin
      term_byte = TN_IAC;
    end else begin
      term_byte = TN_SE;
    end
  end

  always_comb begin
    kind     = K_NET;
    value    = 8'd0;
    discard  = 1'b0;
    lm       = p_q.lm_pre;
    seg_last = CntW'(0);
    case (low)
      SEG_HEAD: begin
        kind    = p_q.head_kind;
        value   = p_q.head_value;
        discard = p_q.head_discard;
        lm      = p_q.head_lm;
      end
      SEG_REPLY: begin
        seg_last = CntW'(2);
        if (cnt_q == CntW'(0)) begin
          value = TN_IAC;
        end else if (cnt_q == CntW'(1)) begin
          value = p_q.reply_verb;
        end else begin
          value = p_q.reply_opt;
        end
      end
      SEG_TERM: begin
        seg_last = CntW'(TermLast);
        value    = term_byte;
      end
      SEG_MODE: begin
        kind = p_q.mode_disc ? K_DISC : K_ENTER3270;
        lm   = p_q.mode_disc ? 1'b1 : p_q.lm_pre;
      end
      SEG_LINE: begin
        kind = K_LINEMODE;
        lm   = p_q.lm_post;
      end
      SEG_EOR: begin
        seg_last = CntW'(2);
        if (cnt_q == CntW'(0)) begin
          value = TN_IAC;
        end else if (cnt_q == CntW'(1)) begin
          value = TN_DO;
        end else begin
          value = OPT_EOR;
        end
      end
      default: kind = K_NET;
    endcase
  end

  assign last_in_seg = (cnt_q == seg_last);
  assign last        = last_in_seg && ((rem_q & ~low) == 6'd0);
  assign out_valid_o = (rem_q != 6'd0);
  assign take_o      = !out_valid_o || (out_ready_i && last);

  assign kind_o      = kind;
  assign value_o     = value;
  assign discard_o   = discard;
  assign line_mode_o = lm;
  assign last_o      = last;

  always_comb begin
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (load_i) begin
      rem_d = plan_i.seg;
      cnt_d = '0;
    end else if (out_valid_o && out_ready_i) begin
      if (last_in_seg) begin
        rem_d = rem_q & ~low;
        cnt_d = '0;
      end else begin
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      cnt_q <= '0;
    end else begin
      rem_q <= rem_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      p_q <= plan_i;
    end
  end

endmodule
